>>> rtl/trm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_pkg: shared types and codes of the register machine execute block
// Opcodes, operand kinds, error codes, write selects and the structs that
// pass between the pipeline register and the execute unit.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int DataW = 32;
  localparam int LineW = 16;

  typedef enum logic [2:0] {
    OP_MOV = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_JMP = 3'd3,
    OP_JPN = 3'd4,
    OP_PRN = 3'd5,
    OP_HLT = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_CONST = 2'd0,
    KIND_REG   = 2'd1,
    KIND_MEM   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_REG    = 2'd1,
    ERR_ADDR   = 2'd2,
    ERR_OPCODE = 2'd3
  } err_e;

  // Where the single write of an instruction lands.
  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_RF_A  = 3'd1,  // register named by the first operand
    WR_RF_B  = 3'd2,  // register named by the second operand
    WR_MEM_1 = 3'd3,  // address named by the first operand
    WR_MEM_2 = 3'd4   // address named by the second operand
  } wr_sel_e;

  // Decoded instruction held in the execute stage.
  typedef struct packed {
    logic [2:0]       opcode;
    logic [1:0]       first_kind;
    logic [1:0]       second_kind;
    logic [DataW-1:0] first_const;
    logic [DataW-1:0] second_const;
    logic             reg1_ok;
    logic             reg2_ok;
    logic             mem1_ok;
    logic             mem2_ok;
  } item_t;

  // Outcome of one instruction.
  typedef struct packed {
    err_e             err;
    logic [LineW-1:0] npc;
    logic             halt_set;
    logic             print_valid;
    logic [DataW-1:0] print_value;
    wr_sel_e          wr_sel;
    logic [DataW-1:0] wr_data;
  } exec_res_t;

endpackage

>>> rtl/trm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_ram: generic single-port-write, single-port-read RAM
// Registered read; a read at the address being written returns the old word.
// ----------------------------------------------------------------------------
module trm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/trm_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_alu: execute unit of the register machine
// Turns a decoded instruction and its forwarded operands into the next
// program counter, print value, halt flag, error code and at most one write.
// ----------------------------------------------------------------------------
module trm_alu (
  input  trm_pkg::item_t                 item_i,
  input  logic [trm_pkg::DataW-1:0]      opa_i,  // register at first operand
  input  logic [trm_pkg::DataW-1:0]      opb_i,  // register at second operand
  input  logic [trm_pkg::DataW-1:0]      opm_i,  // memory word read
  input  logic [trm_pkg::LineW-1:0]      pc_i,
  output trm_pkg::exec_res_t             res_o
);

  import trm_pkg::*;

  logic [DataW-1:0] rhs;
  logic [DataW-1:0] sum;
  logic [DataW-1:0] diff;

  always_comb begin
    case (item_i.second_kind)
      KIND_REG: rhs = opb_i;
      KIND_MEM: rhs = opm_i;
      default:  rhs = item_i.second_const;
    endcase
  end

  assign sum  = opa_i + rhs;
  assign diff = opa_i - rhs;

  always_comb begin
    res_o             = '0;
    res_o.err         = ERR_NONE;
    res_o.npc         = pc_i + LineW'(1);
    res_o.wr_sel      = WR_NONE;
    res_o.print_value = '0;

    case (item_i.opcode)
      OP_MOV: begin
        if (item_i.first_kind == KIND_REG) begin
          if (!item_i.reg1_ok) begin
            res_o.err = ERR_REG;
          end else if (item_i.second_kind == KIND_REG && !item_i.reg2_ok) begin
            res_o.err = ERR_REG;
          end else if (item_i.second_kind == KIND_MEM && !item_i.mem2_ok) begin
            res_o.err = ERR_ADDR;
          end else if (item_i.second_kind == KIND_REG) begin
            res_o.wr_sel  = WR_RF_B;
            res_o.wr_data = opa_i;
          end else if (item_i.second_kind == KIND_MEM) begin
            res_o.wr_sel  = WR_MEM_2;
            res_o.wr_data = opa_i;
          end else begin
            res_o.wr_sel  = WR_RF_A;
            res_o.wr_data = item_i.second_const;
          end
        end else if (item_i.first_kind == KIND_MEM) begin
          if (!item_i.mem1_ok) begin
            res_o.err = ERR_ADDR;
          end else if (item_i.second_kind == KIND_REG && !item_i.reg2_ok) begin
            res_o.err = ERR_REG;
          end else if (item_i.second_kind == KIND_REG) begin
            res_o.wr_sel  = WR_RF_B;
            res_o.wr_data = opm_i;
          end else begin
            res_o.wr_sel  = WR_MEM_1;
            res_o.wr_data = item_i.second_const;
          end
        end
      end
      OP_ADD, OP_SUB: begin
        if (!item_i.reg1_ok) begin
          res_o.err = ERR_REG;
        end else if (item_i.second_kind == KIND_REG && !item_i.reg2_ok) begin
          res_o.err = ERR_REG;
        end else if (item_i.second_kind == KIND_MEM && !item_i.mem2_ok) begin
          res_o.err = ERR_ADDR;
        end else begin
          res_o.wr_sel  = WR_RF_A;
          res_o.wr_data = (item_i.opcode == OP_ADD) ? sum : diff;
        end
      end
      OP_JMP: begin
        if (item_i.first_kind == KIND_REG) begin
          if (!item_i.reg1_ok) begin
            res_o.err = ERR_REG;
          end else if (opa_i == '0) begin
            res_o.npc = item_i.second_const[LineW-1:0];
          end
        end else begin
          res_o.npc = item_i.first_const[LineW-1:0];
        end
      end
      OP_JPN: begin
        if (!item_i.reg1_ok) begin
          res_o.err = ERR_REG;
        end else if (opa_i == '0 || opa_i[DataW-1]) begin
          res_o.npc = item_i.second_const[LineW-1:0];
        end
      end
      OP_PRN: begin
        if (item_i.first_kind == KIND_REG && !item_i.reg1_ok) begin
          res_o.err = ERR_REG;
        end else if (item_i.first_kind == KIND_MEM && !item_i.mem1_ok) begin
          res_o.err = ERR_ADDR;
        end else begin
          res_o.print_valid = 1'b1;
          case (item_i.first_kind)
            KIND_REG: res_o.print_value = opa_i;
            KIND_MEM: res_o.print_value = opm_i;
            default:  res_o.print_value = item_i.first_const;
          endcase
        end
      end
      OP_HLT: begin
        res_o.halt_set = 1'b1;
        res_o.npc      = pc_i;
      end
      default: begin
        res_o.err = ERR_OPCODE;
      end
    endcase

    // A failed instruction changes nothing.
    if (res_o.err != ERR_NONE) begin
      res_o.npc    = pc_i;
      res_o.wr_sel = WR_NONE;
    end
  end

endmodule

>>> rtl/tiny_register_machine_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_register_machine_execute: execute stage of a small register machine
// Runs one decoded instruction per transaction against a register file and
// a data memory held in synchronous RAMs, and reports one result each.
// ----------------------------------------------------------------------------
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------
//   input    | in_valid_i / in_stall_o | opcode, first/second kind+value,
//            |                         | second_present
//   output   | out_valid_o/out_stall_i | print_valid, print_value,
//            |                         | next_line, halted, error_code
//
// Flow: one instruction per clock while the output is not stalled. An
//   instruction is accepted into the execute stage registers (RAM reads
//   launch), then executes, writes back and fills the output register.
// Reset: after reset the RAMs are swept to zero, one entry per cycle,
//   through max(REGISTER_COUNT, MEMORY_WORDS) entries (64 by default);
//   in_stall_o stays high during the sweep.
// Stalls: the output register decouples the sides; the input stalls only
//   during the init sweep or when both the execute stage and the output
//   register are full and the output is stalled.
// A write by the instruction ahead that lands on the same edge as the read
//   is forwarded from a bypass register.
// second_present_i is carried on the port; no opcode depends on it.
// ----------------------------------------------------------------------------
module tiny_register_machine_execute #(
  parameter int REGISTER_COUNT = 5,
  parameter int MEMORY_WORDS   = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       opcode_i,
  input  logic [1:0]                       first_kind_i,
  input  logic signed [trm_pkg::DataW-1:0] first_value_i,
  input  logic [1:0]                       second_kind_i,
  input  logic signed [trm_pkg::DataW-1:0] second_value_i,
  input  logic                             second_present_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             print_valid_o,
  output logic signed [trm_pkg::DataW-1:0] print_value_o,
  output logic [trm_pkg::LineW-1:0]        next_line_o,
  output logic                             halted_o,
  output logic [1:0]                       error_code_o
);

  import trm_pkg::*;

  localparam int RegIdxW   = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int MemAddrW  = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
  localparam int ClrDepth  = (REGISTER_COUNT > MEMORY_WORDS) ? REGISTER_COUNT
                                                             : MEMORY_WORDS;
  localparam int ClrCntW   = $clog2(ClrDepth + 1);
  localparam logic signed [DataW-1:0] RegMax  = DataW'(REGISTER_COUNT);
  localparam logic signed [DataW-1:0] MemLast = DataW'(MEMORY_WORDS - 1);

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic in_accept;
  logic s1_fire;
  logic s1_valid_q;
  logic out_valid_q;
  logic init_q;
  logic [ClrCntW-1:0] init_cnt_q;

  // Execute stage fires when the output register is empty or draining.
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = init_q || (s1_valid_q && !s1_fire);
  assign in_accept  = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Decode on accept: range checks and RAM addresses
  // ---------------------------------------------------------------------------
  item_t               item_d;
  logic [DataW-1:0]    v1_m1;
  logic [DataW-1:0]    v2_m1;
  logic [RegIdxW-1:0]  ra_d;
  logic [RegIdxW-1:0]  rb_d;
  logic [MemAddrW-1:0] m1_d;
  logic [MemAddrW-1:0] m2_d;
  logic [MemAddrW-1:0] mrd_d;

  assign v1_m1 = first_value_i - DataW'(1);
  assign v2_m1 = second_value_i - DataW'(1);
  assign ra_d  = v1_m1[RegIdxW-1:0];
  assign rb_d  = v2_m1[RegIdxW-1:0];
  assign m1_d  = first_value_i[MemAddrW-1:0];
  assign m2_d  = second_value_i[MemAddrW-1:0];
  // ADD and SUB read memory at the second operand, everything else at the first.
  assign mrd_d = (opcode_i inside {OP_ADD, OP_SUB}) ? m2_d : m1_d;

  always_comb begin
    item_d.opcode       = opcode_i;
    item_d.first_kind   = first_kind_i;
    item_d.second_kind  = second_kind_i;
    item_d.first_const  = first_value_i;
    item_d.second_const = second_value_i;
    item_d.reg1_ok      = (first_value_i >= 1) && (first_value_i <= RegMax);
    item_d.reg2_ok      = (second_value_i >= 1) && (second_value_i <= RegMax);
    item_d.mem1_ok      = !first_value_i[DataW-1] && (first_value_i <= MemLast);
    item_d.mem2_ok      = !second_value_i[DataW-1] && (second_value_i <= MemLast);
  end

  // ---------------------------------------------------------------------------
  // Execute stage registers
  // ---------------------------------------------------------------------------
  item_t               s1_item_q;
  logic [RegIdxW-1:0]  s1_ra_q;
  logic [RegIdxW-1:0]  s1_rb_q;
  logic [MemAddrW-1:0] s1_m1_q;
  logic [MemAddrW-1:0] s1_m2_q;
  logic [MemAddrW-1:0] s1_mrd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= item_d;
      s1_ra_q   <= ra_d;
      s1_rb_q   <= rb_d;
      s1_m1_q   <= m1_d;
      s1_m2_q   <= m2_d;
      s1_mrd_q  <= mrd_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: register file in two read banks, data memory in one
  // ---------------------------------------------------------------------------
  logic                rf_we;
  logic [RegIdxW-1:0]  rf_waddr;
  logic                mem_we;
  logic [MemAddrW-1:0] mem_waddr;
  logic [DataW-1:0]    wdata;
  logic [DataW-1:0]    rfa_rdata;
  logic [DataW-1:0]    rfb_rdata;
  logic [DataW-1:0]    mem_rdata;

  trm_ram #(
    .Width (DataW),
    .Depth (REGISTER_COUNT),
    .AddrW (RegIdxW)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (wdata),
    .re_i    (in_accept),
    .raddr_i (ra_d),
    .rdata_o (rfa_rdata)
  );

  trm_ram #(
    .Width (DataW),
    .Depth (REGISTER_COUNT),
    .AddrW (RegIdxW)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (wdata),
    .re_i    (in_accept),
    .raddr_i (rb_d),
    .rdata_o (rfb_rdata)
  );

  trm_ram #(
    .Width (DataW),
    .Depth (MEMORY_WORDS),
    .AddrW (MemAddrW)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wdata),
    .re_i    (in_accept),
    .raddr_i (mrd_d),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Bypass: hold the write that landed on the same edge as the current read
  // ---------------------------------------------------------------------------
  logic                fwd_rf_we_q;
  logic [RegIdxW-1:0]  fwd_rf_addr_q;
  logic                fwd_mem_we_q;
  logic [MemAddrW-1:0] fwd_mem_addr_q;
  logic [DataW-1:0]    fwd_data_q;
  logic                exec_rf_we;
  logic                exec_mem_we;
  logic [DataW-1:0]    opa;
  logic [DataW-1:0]    opb;
  logic [DataW-1:0]    opm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_rf_we_q  <= 1'b0;
      fwd_mem_we_q <= 1'b0;
    end else if (in_accept) begin
      fwd_rf_we_q  <= exec_rf_we;
      fwd_mem_we_q <= exec_mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_rf_addr_q  <= rf_waddr;
      fwd_mem_addr_q <= mem_waddr;
      fwd_data_q     <= wdata;
    end
  end

  assign opa = (fwd_rf_we_q && fwd_rf_addr_q == s1_ra_q) ? fwd_data_q : rfa_rdata;
  assign opb = (fwd_rf_we_q && fwd_rf_addr_q == s1_rb_q) ? fwd_data_q : rfb_rdata;
  assign opm = (fwd_mem_we_q && fwd_mem_addr_q == s1_mrd_q) ? fwd_data_q : mem_rdata;

  // ---------------------------------------------------------------------------
  // Execute and write back
  // ---------------------------------------------------------------------------
  exec_res_t        res;
  logic [LineW-1:0] pc_q;
  logic             halt_q;

  trm_alu u_alu (
    .item_i (s1_item_q),
    .opa_i  (opa),
    .opb_i  (opb),
    .opm_i  (opm),
    .pc_i   (pc_q),
    .res_o  (res)
  );

  assign exec_rf_we  = s1_fire && (res.wr_sel inside {WR_RF_A, WR_RF_B});
  assign exec_mem_we = s1_fire && (res.wr_sel inside {WR_MEM_1, WR_MEM_2});

  // Drive the write ports from the init sweep first, then from execute.
  always_comb begin
    if (init_q) begin
      rf_we     = init_cnt_q < ClrCntW'(REGISTER_COUNT);
      rf_waddr  = init_cnt_q[RegIdxW-1:0];
      mem_we    = init_cnt_q < ClrCntW'(MEMORY_WORDS);
      mem_waddr = init_cnt_q[MemAddrW-1:0];
      wdata     = '0;
    end else begin
      rf_we     = exec_rf_we;
      rf_waddr  = (res.wr_sel == WR_RF_B) ? s1_rb_q : s1_ra_q;
      mem_we    = exec_mem_we;
      mem_waddr = (res.wr_sel == WR_MEM_2) ? s1_m2_q : s1_m1_q;
      wdata     = res.wr_data;
    end
  end

  // Init sweep: advance one entry per cycle, drop out after the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= 1'b1;
      init_cnt_q <= '0;
    end else if (init_q) begin
      init_cnt_q <= init_cnt_q + ClrCntW'(1);
      if (init_cnt_q == ClrCntW'(ClrDepth - 1)) begin
        init_q <= 1'b0;
      end
    end
  end

  // Program counter and sticky halt.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= LineW'(1);
      halt_q <= 1'b0;
    end else if (s1_fire) begin
      pc_q   <= res.npc;
      halt_q <= halt_q | res.halt_set;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic             print_valid_q;
  logic [DataW-1:0] print_value_q;
  logic [LineW-1:0] next_line_q;
  logic             halted_q;
  err_e             error_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      print_valid_q <= res.print_valid;
      print_value_q <= res.print_value;
      next_line_q   <= res.npc;
      halted_q      <= halt_q | res.halt_set;
      error_code_q  <= res.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign print_valid_o = print_valid_q;
  assign print_value_o = print_value_q;
  assign next_line_o   = next_line_q;
  assign halted_o      = halted_q;
  assign error_code_o  = error_code_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_err_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && res.err != ERR_NONE) |-> (!exec_rf_we && !exec_mem_we))
    else $error("failed instruction wrote state");

  a_err_holds_pc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && res.err != ERR_NONE) |=> (pc_q == $past(pc_q)))
    else $error("failed instruction moved the program counter");

  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

  a_fire_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (out_valid_o && next_line_o == pc_q))
    else $error("executed instruction did not reach the output register");

  a_no_exec_in_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> (!s1_valid_q && !in_accept))
    else $error("instruction active during init sweep");

endmodule
